// ----- rtl/bpfa_pkg.sv -----
// shared constants and types for the bitmap page frame allocator
// no dependencies; used by the top level, bpfa_ffs and the testbench
package bpfa_pkg;

	localparam int PAGE_COUNT_DEF = 4096;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam logic [31:0] BASE_RESET = 32'h0010_0000;

	// bitmap word geometry
	localparam int WORD_BITS = 32;
	localparam int BIT_W = 5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_OOM = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	// outcome of one word scan
	typedef struct packed {
		logic found;
		logic [BIT_W-1:0] bit_pos;
	} ffs_res_t;

endpackage

// ----- rtl/bitmap_page_frame_allocator_top.sv -----
// top level of the bitmap page frame allocator: sequencer, hint, base register
// depends on bpfa_pkg, bpfa_ram, bpfa_ffs and bpfa_div
//
// Hands out and takes back physical pages of PAGE_BYTES bytes (a power of two) from a
// region of PAGE_COUNT pages starting at region_base, first fit from a lowest-free hint.
// After reset the used-bit map, kept as 32-bit words in a ram, is cleared by a
// pass over every word during which no item is accepted. One item is worked on
// at a time. An allocate reads bitmap words one after another, one ram read and
// one scan per word, starting at the hint's word, then forms the page address;
// one that finds no free page answers out of memory after the last word, and
// with the hint already at the top it answers out of memory without a read. A
// free does a range check, finds the page number by a shift of the byte offset,
// then a read-modify-write of one word; a free outside the region ends after the
// range check. The result waits in an output register while the next item may
// be accepted; region_base may be written at any time the block is idle and does
// not touch the bitmap or the hint.
module bitmap_page_frame_allocator_top #(
	parameter int PAGE_COUNT = bpfa_pkg::PAGE_COUNT_DEF,
	parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	input  logic [31:0] free_address,
	// result channel
	output logic out_valid,
	input  logic out_ready,
	output logic [31:0] page_address,
	output logic [1:0] status,
	// region base register write
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [31:0] region_base
);

	localparam int WB = bpfa_pkg::WORD_BITS;
	localparam int BW = bpfa_pkg::BIT_W;
	localparam int WORDS = (PAGE_COUNT + WB - 1) / WB;
	localparam int WADDR_W = WORDS > 1 ? $clog2(WORDS) : 1;
	localparam int FI_W = WADDR_W + BW;
	localparam int IDX_W = $clog2(PAGE_COUNT);
	localparam int HINT_W = $clog2(PAGE_COUNT + 1);
	localparam int LAST_BITS = PAGE_COUNT - (WORDS - 1) * WB;
	localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
	localparam logic [HINT_W-1:0] HINT_TOP = HINT_W'(PAGE_COUNT);
	localparam logic [32:0] RANGE_BYTES = 33'(longint'(PAGE_COUNT) * longint'(PAGE_BYTES));
	localparam logic [31:0] PAGE_BYTES_W = 32'(PAGE_BYTES);

	// sequencer states
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_A_RD = 4'd2;
	localparam logic [3:0] ST_A_CHK = 4'd3;
	localparam logic [3:0] ST_A_ADDR = 4'd4;
	localparam logic [3:0] ST_F_CHK = 4'd5;
	localparam logic [3:0] ST_F_DIV = 4'd6;
	localparam logic [3:0] ST_F_RD = 4'd7;
	localparam logic [3:0] ST_F_WR = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0] state_q;
	logic [WADDR_W-1:0] clr_cnt_q;
	logic [HINT_W-1:0] hint_q;
	logic [31:0] base_q;
	logic out_valid_q;

	// per-item working registers
	logic [31:0] addr_q;
	logic [WADDR_W-1:0] ptr_q;
	logic first_q;
	logic [31:0] prod_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0] res_addr_q;
	logic [1:0] res_status_q;
	logic [31:0] page_addr_q;
	logic [1:0] status_q;

	// ram ports
	logic ram_we;
	logic [WADDR_W-1:0] ram_waddr;
	logic [WB-1:0] ram_wdata;
	logic ram_re;
	logic [WADDR_W-1:0] ram_raddr;
	logic [WB-1:0] ram_rdata;

	bpfa_pkg::ffs_res_t scan;
	logic [FI_W-1:0] hint_ext;
	logic [FI_W-1:0] idx_ext;
	logic [FI_W-1:0] found_idx;
	logic [32:0] diff;
	logic free_bad;
	logic hint_full;
	logic accept;
	logic out_load;
	logic div_done;
	logic [IDX_W-1:0] div_quot;

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign hint_ext = FI_W'(hint_q);
	assign idx_ext = FI_W'(idx_q);
	assign found_idx = {ptr_q, scan.bit_pos};
	assign hint_full = (hint_q >= HINT_TOP);

	// free range check: below base, or offset past the last page
	assign diff = {1'b0, addr_q} - {1'b0, base_q};
	assign free_bad = diff[32] || ({1'b0, diff[31:0]} >= RANGE_BYTES);

	bpfa_ram #(
		.WIDTH(WB),
		.DEPTH(WORDS)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// scan of the word just read; the hint word is masked below the hint bit
	bpfa_ffs #(
		.LAST_BITS(LAST_BITS)
	) u_scan (
		.word(ram_rdata),
		.first(first_q),
		.start_bit(hint_ext[BW-1:0]),
		.last(ptr_q == LAST_WORD),
		.res(scan)
	);

	bpfa_div #(
		.PAGE_BYTES(PAGE_BYTES),
		.QW(IDX_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start((state_q == ST_F_CHK) && !free_bad),
		.dividend(diff[31:0]),
		.done(div_done),
		.quotient(div_quot)
	);

	// ram access per state
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = ptr_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_cnt_q;
			end
			ST_A_RD: begin
				ram_re = 1'b1;
			end
			ST_A_CHK: begin
				// mark the page found as used
				ram_we = scan.found;
				ram_wdata = ram_rdata | ({{(WB-1){1'b0}}, 1'b1} << scan.bit_pos);
			end
			ST_F_RD: begin
				ram_re = 1'b1;
				ram_raddr = idx_ext[FI_W-1:BW];
			end
			ST_F_WR: begin
				ram_we = 1'b1;
				ram_waddr = idx_ext[FI_W-1:BW];
				ram_wdata = ram_rdata & ~({{(WB-1){1'b0}}, 1'b1} << idx_ext[BW-1:0]);
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			hint_q <= '0;
			base_q <= bpfa_pkg::BASE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				base_q <= region_base;
			end
			// a new result may replace the one taken at this edge
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (opcode == bpfa_pkg::OP_FREE) begin
							state_q <= ST_F_CHK;
						end else if (hint_full) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_A_RD;
						end
					end
				end
				ST_A_RD: begin
					state_q <= ST_A_CHK;
				end
				ST_A_CHK: begin
					if (scan.found) begin
						hint_q <= HINT_W'(found_idx) + 1'b1;
						state_q <= ST_A_ADDR;
					end else if (ptr_q == LAST_WORD) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_A_RD;
					end
				end
				ST_A_ADDR: begin
					state_q <= ST_DONE;
				end
				ST_F_CHK: begin
					state_q <= free_bad ? ST_DONE : ST_F_DIV;
				end
				ST_F_DIV: begin
					if (div_done) begin
						state_q <= ST_F_RD;
					end
				end
				ST_F_RD: begin
					state_q <= ST_F_WR;
				end
				ST_F_WR: begin
					// a freed page below the hint becomes the new hint
					if (HINT_W'(idx_q) < hint_q) begin
						hint_q <= HINT_W'(idx_q);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					addr_q <= free_address;
					ptr_q <= hint_ext[FI_W-1:BW];
					first_q <= 1'b1;
					res_addr_q <= '0;
					res_status_q <= (opcode == bpfa_pkg::OP_ALLOC && hint_full) ?
						bpfa_pkg::STATUS_OOM : bpfa_pkg::STATUS_DONE;
				end
			end
			ST_A_CHK: begin
				first_q <= 1'b0;
				if (scan.found) begin
					prod_q <= 32'(found_idx) * PAGE_BYTES_W;
				end else begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_WORD) begin
						res_status_q <= bpfa_pkg::STATUS_OOM;
					end
				end
			end
			ST_A_ADDR: begin
				// address wraps modulo 2^32
				res_addr_q <= base_q + prod_q;
			end
			ST_F_CHK: begin
				if (free_bad) begin
					res_status_q <= bpfa_pkg::STATUS_RANGE;
				end
			end
			ST_F_DIV: begin
				if (div_done) begin
					idx_q <= div_quot;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					page_addr_q <= res_addr_q;
					status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign page_address = page_addr_q;
	assign status = status_q;

endmodule

// ----- rtl/bpfa_ram.sv -----
// generic single-write, single-read ram with registered read data
// no package dependencies
module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/bpfa_ffs.sv -----
// word scan unit: masks one bitmap word and finds its lowest free bit
// depends on bpfa_pkg
module bpfa_ffs #(
	parameter int LAST_BITS = 32
) (
	input  logic [bpfa_pkg::WORD_BITS-1:0] word,
	input  logic first,
	input  logic [bpfa_pkg::BIT_W-1:0] start_bit,
	input  logic last,
	output bpfa_pkg::ffs_res_t res
);

	localparam logic [bpfa_pkg::WORD_BITS-1:0] ONES = '1;
	localparam logic [bpfa_pkg::WORD_BITS-1:0] LAST_MASK =
		ONES >> (bpfa_pkg::WORD_BITS - LAST_BITS);

	logic [bpfa_pkg::WORD_BITS-1:0] free_m;
	logic [bpfa_pkg::WORD_BITS-1:0] lowest;
	logic [bpfa_pkg::BIT_W-1:0] pos;

	always_comb begin
		free_m = ~word & (first ? (ONES << start_bit) : ONES) & (last ? LAST_MASK : ONES);
		// isolate the lowest set bit, then encode the one-hot result
		lowest = free_m & (~free_m + {{(bpfa_pkg::WORD_BITS-1){1'b0}}, 1'b1});
		pos = '0;
		for (int b = 0; b < bpfa_pkg::WORD_BITS; b++) begin
			if (lowest[b]) begin
				pos = pos | bpfa_pkg::BIT_W'(b);
			end
		end
		res.found = |free_m;
		res.bit_pos = pos;
	end

endmodule

// ----- rtl/bpfa_div.sv -----
// page number unit: byte offset to page number by a shift, page size a power of two
// no package dependencies; started by the allocator top level
module bpfa_div #(
	parameter int PAGE_BYTES = 4096,
	parameter int QW = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] dividend,
	output logic done,
	output logic [QW-1:0] quotient
);

	localparam int SHIFT = $clog2(PAGE_BYTES);

	logic [QW-1:0] quot_q;
	logic done_q;

	// result is ready the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// offset is known to be below page size shifted by QW
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= QW'(dividend >> SHIFT);
		end
	end

	assign done = done_q;
	assign quotient = quot_q;

endmodule

// ----- tb/sv/bitmap_page_frame_allocator_top_tb.sv -----
// self-checking testbench for bitmap_page_frame_allocator_top: directed table, then random
// alloc/free traffic with base changes, checked against an in-bench allocator model
// depends on bpfa_pkg and the allocator rtl
module bitmap_page_frame_allocator_top_tb;
	import bpfa_pkg::*;

	localparam int PAGES = PAGE_COUNT_DEF;
	localparam int FRAME_BYTES = PAGE_BYTES_DEF;
	localparam longint REGION_SPAN = longint'(PAGES) * FRAME_BYTES;
	localparam int RANDOM_ITEMS = 1650;
	// worst allocate walks every bitmap word, plus the long receiver
	// hold-off, the longest sender gap and the clearing pass, taken many times over
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [31:0] page_address;
		logic [1:0] status;
	} frame_result_t;

	typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic op;
		logic [31:0] data;
		logic typed;
		logic [31:0] exp_address;
		logic [1:0] exp_status;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic opcode;
	logic [31:0] free_address;
	logic out_valid;
	logic out_ready;
	logic [31:0] page_address;
	logic [1:0] status;
	logic cfg_valid;
	logic cfg_ready;
	logic [31:0] region_base;

	// allocator model state: one used bit per page, lowest-free hint, base register
	logic [PAGES-1:0] frame_used;
	int lowest_free;
	logic [31:0] base_model;

	frame_result_t pending_results[$];
	int fail_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int random_items = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	// directed rows; expectations are typed in where they follow directly from
	// the base and the pages handed out so far, the rest go through the model
	directed_row_t directed_rows [25] = '{
		// fresh map at the reset base: first two pages, then page 0 freed twice
		'{ROW_REQUEST, OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'h0010_1000, STATUS_DONE},
		// unaligned free hits the containing page
		'{ROW_REQUEST, OP_FREE, 32'h0010_0800, 1'b1, 32'h0000_0000, STATUS_DONE},
		// double free is harmless
		'{ROW_REQUEST, OP_FREE, 32'h0010_0000, 1'b1, 32'h0000_0000, STATUS_DONE},
		// hint was lowered, so page 0 comes back
		'{ROW_REQUEST, OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_0000, STATUS_DONE},
		// one byte below base, address zero, one byte past the region
		'{ROW_REQUEST, OP_FREE, 32'h000F_FFFF, 1'b1, 32'h0000_0000, STATUS_RANGE},
		'{ROW_REQUEST, OP_FREE, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_RANGE},
		'{ROW_REQUEST, OP_FREE, 32'h0110_0000, 1'b1, 32'h0000_0000, STATUS_RANGE},
		// last byte of the last page
		'{ROW_REQUEST, OP_FREE, 32'h010F_FFFF, 1'b1, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_RANGE},
		// base at zero; map and hint survive the write
		'{ROW_CONFIG, OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_ALLOC, 32'h1234_5678, 1'b1, 32'h0000_2000, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'h00FF_FFFF, 1'b1, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'h0100_0000, 1'b1, 32'h0000_0000, STATUS_RANGE},
		// highest base: region ends at the top of the address space
		'{ROW_CONFIG, OP_ALLOC, 32'hFF00_0000, 1'b0, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_ALLOC, 32'h0000_0000, 1'b1, 32'hFF00_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'hFEFF_FFFF, 1'b1, 32'h0000_0000, STATUS_RANGE},
		'{ROW_REQUEST, OP_FREE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'hFF00_0000, 1'b0, 32'h0000_0000, STATUS_DONE},
		// unaligned base is used as written
		'{ROW_CONFIG, OP_ALLOC, 32'h0012_3456, 1'b0, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0012_3456, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'h0012_4455, 1'b1, 32'h0000_0000, STATUS_DONE},
		'{ROW_REQUEST, OP_FREE, 32'h0012_3455, 1'b1, 32'h0000_0000, STATUS_RANGE},
		'{ROW_REQUEST, OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0012_3456, STATUS_DONE}
	};

	bitmap_page_frame_allocator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.free_address(free_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.page_address(page_address),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.region_base(region_base)
	);

	always #5 clk = ~clk;

	// first fit from the hint on allocate; page lookup, clear and hint lowering on free
	function automatic frame_result_t predict_frame_result(input logic op,
			input logic [31:0] addr);
		frame_result_t res;
		logic [31:0] offset;
		logic [31:0] frame_num;
		res.page_address = '0;
		res.status = STATUS_OOM;
		if (op == OP_ALLOC) begin
			for (int i = lowest_free; i < PAGES; i++) begin
				if (!frame_used[i]) begin
					frame_used[i] = 1'b1;
					lowest_free = i + 1;
					// wraps modulo 2^32 by the width of the sum
					res.page_address = base_model + 32'(i) * 32'(FRAME_BYTES);
					res.status = STATUS_DONE;
					break;
				end
			end
		end else if (addr < base_model) begin
			res.status = STATUS_RANGE;
		end else begin
			offset = addr - base_model;
			frame_num = offset / 32'(FRAME_BYTES);
			if (frame_num >= 32'(PAGES)) begin
				res.status = STATUS_RANGE;
			end else begin
				frame_used[frame_num] = 1'b0;
				if (int'(frame_num) < lowest_free)
					lowest_free = int'(frame_num);
				res.status = STATUS_DONE;
			end
		end
		return res;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// a page the model holds as used, or any page if none is
	function automatic int pick_live_page();
		int start;
		int idx;
		start = $urandom_range(0, PAGES - 1);
		for (int k = 0; k < PAGES; k++) begin
			idx = (start + k) % PAGES;
			if (frame_used[idx])
				return idx;
		end
		return start;
	endfunction

	// free targets: live pages (some unaligned), any page, just below base,
	// just past the region, and raw noise
	function automatic logic [31:0] make_free_address();
		longint lo;
		longint hi;
		int roll;
		int idx;
		int byte_off;
		lo = longint'(base_model);
		hi = lo + REGION_SPAN;
		roll = $urandom_range(0, 99);
		byte_off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FRAME_BYTES - 1) : 0;
		if (roll < 70) begin
			idx = (roll < 55) ? pick_live_page() : $urandom_range(0, PAGES - 1);
			return 32'(lo + longint'(idx) * FRAME_BYTES + byte_off);
		end
		if (roll < 80 && lo > 0)
			return 32'(lo - $urandom_range(1, (lo < FRAME_BYTES) ? int'(lo) : FRAME_BYTES));
		if (roll < 90 && hi + 64'h3FFF <= 64'hFFFF_FFFF)
			return 32'(hi + $urandom_range(0, 16'h3FFF));
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_region_base();
		case ($urandom_range(0, 4))
			0: return BASE_RESET;
			1: return 32'h0000_0000;
			2: return 32'hFF00_0000;
			3: return 32'($urandom_range(0, 32'h000F_F000)) << 12;
			default: return $urandom_range(0, 32'hFF00_0000);
		endcase
	endfunction

	// drive one request from a falling edge, wait for the handshake, record the
	// expected result; returns at the next falling edge with valid still up
	task automatic send_request(input logic op, input logic [31:0] addr,
			input logic use_typed, input frame_result_t typed_result,
			output frame_result_t predicted);
		int gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		free_address <= addr;
		do @(posedge clk); while (!in_ready);
		predicted = predict_frame_result(op, addr);
		pending_results.push_back(use_typed ? typed_result : predicted);
		@(negedge clk);
	endtask

	// base is only written with nothing in flight
	task automatic write_region_base(input logic [31:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		region_base <= value;
		do @(posedge clk); while (!cfg_ready);
		base_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item(input int alloc_pct);
		frame_result_t got;
		if ($urandom_range(0, 99) < alloc_pct)
			send_request(OP_ALLOC, $urandom(), 1'b0, '0, got);
		else
			send_request(OP_FREE, make_free_address(), 1'b0, '0, got);
		random_items++;
	endtask

	// request side: reset, directed table, then random phases
	initial begin : stimulus
		frame_result_t got;
		frame_result_t typed_result;
		int phase_len;
		int alloc_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ALLOC;
		free_address = '0;
		cfg_valid = 1'b0;
		region_base = BASE_RESET;
		frame_used = '0;
		lowest_free = 0;
		base_model = BASE_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CONFIG) begin
				write_region_base(directed_rows[r].data);
			end else begin
				typed_result.page_address = directed_rows[r].exp_address;
				typed_result.status = directed_rows[r].exp_status;
				send_request(directed_rows[r].op, directed_rows[r].data,
					directed_rows[r].typed, typed_result, got);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			write_region_base(pick_region_base());
			tx_quiet = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(60, 180);
			case ($urandom_range(0, 3))
				0: alloc_pct = 30;
				1: alloc_pct = 50;
				2: alloc_pct = 70;
				default: alloc_pct = 90;
			endcase
			repeat (phase_len) send_random_item(alloc_pct);
		end

		// drain, then wait for stray results
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// result side: random stalls, quiet stretches, and one long hold-off while
	// the sender keeps offering so the block backs up into its input
	initial begin : result_sink
		int stall;
		bit held;
		out_ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 199) == 0)
				rx_quiet = ~rx_quiet;
			if (!held && results_seen >= 500 && in_valid) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end else begin
				stall = rx_quiet ? 0 : pick_gap();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: page_address %h status %0d",
					page_address, status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (page_address !== want.page_address) begin
					$error("page_address: expected %h, got %h", want.page_address,
						page_address);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	// ends the run after too long without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
